// ----- rtl/mos_pkg.sv -----
// Package for the mutation operator scheduler: payload structs, fixed sizes,
// configuration register indexes and small helper functions.
// Depends on nothing; mos_prng, the top level and the testbench import it.
`default_nettype none

package mos_pkg;

  // Fixed population layout of one seed slot.
  localparam int POPULATION    = 20;
  localparam int ELITE_GROUPS  = 4;
  localparam int MAX_OPERATORS = 32;
  localparam int GROUP_SIZE    = POPULATION / ELITE_GROUPS;

  localparam int OP_W   = 5;
  localparam int POS_W  = 5;
  localparam int GRP_W  = 2;
  localparam int PROB_W = 16;
  localparam int FIT_W  = 16;
  localparam int CFG_W  = 32;

  localparam logic [PROB_W-1:0] PROB_HALF = 16'h8000;
  localparam logic [PROB_W-1:0] PROB_MAX  = 16'hFFFF;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_NUM_OPS = 2'd0,
    CFG_RATE    = 2'd1,
    CFG_SEED    = 2'd2
  } cfg_idx_e;

  // One command beat.
  typedef struct packed {
    logic        command;
    logic [5:0]  seed_slot;
    logic [15:0] new_paths;
  } cmd_t;

  // One result beat.
  typedef struct packed {
    logic [4:0] operator_id;
    logic       generation_done;
  } res_t;

  // Elite group that a population position belongs to.
  function automatic logic [GRP_W-1:0] pos_to_group(logic [POS_W-1:0] pos);
    logic [GRP_W-1:0] g;
    if (pos >= POS_W'(3 * GROUP_SIZE)) g = 2'd3;
    else if (pos >= POS_W'(2 * GROUP_SIZE)) g = 2'd2;
    else if (pos >= POS_W'(GROUP_SIZE)) g = 2'd1;
    else g = 2'd0;
    return g;
  endfunction

  // First position of an elite group, which is its best after a restart.
  function automatic logic [POS_W-1:0] group_start(logic [GRP_W-1:0] g);
    logic [POS_W-1:0] p;
    p = POS_W'(g) * POS_W'(GROUP_SIZE);
    return p;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mos_ram.sv -----
// Generic single-port RAM with registered, read-first data output.
// Depends on nothing.
`default_nettype none

module mos_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr_i,
  input  wire logic [WIDTH-1:0]                       wdata_i,
  output logic      [WIDTH-1:0]                       rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write on enable, read the old contents every cycle.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_o <= mem_q[addr_i];
  end

endmodule

`default_nettype wire

// ----- rtl/mos_prng.sv -----
// 32-bit xorshift generator (shifts 13, 17, 5) with seed load.
// Depends on mos_pkg.
`default_nettype none

module mos_prng
  import mos_pkg::*;
(
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             step_i,
  input  wire logic             load_i,
  input  wire logic [CFG_W-1:0] seed_i,
  output logic      [CFG_W-1:0] next_o
);

  logic [31:0] state_q, state_d;
  logic [31:0] x1, x2;

  // Next value of the sequence, seen before it is taken.
  always_comb begin
    x1     = state_q ^ (state_q << 13);
    x2     = x1 ^ (x1 >> 17);
    next_o = x2 ^ (x2 << 5);
  end

  // A zero seed would lock the generator, so it loads one instead.
  always_comb begin
    state_d = state_q;
    if (load_i) begin
      state_d = (seed_i == '0) ? 32'd1 : seed_i;
    end else if (step_i) begin
      state_d = next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= 32'd1;
    end else begin
      state_q <= state_d;
    end
  end

  // The state never reaches zero.
  a_state_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != '0) else $error("prng state is zero");

endmodule

`default_nettype wire

// ----- rtl/mos_mul.sv -----
// Shared registered 32x17 multiplier, used for the random start operator
// and for the probability update. Depends on nothing.
`default_nettype none

module mos_mul (
  input  wire logic        clk_i,
  input  wire logic [31:0] a_i,
  input  wire logic [16:0] b_i,
  output logic      [48:0] prod_o
);

  // The product is registered and ready in the cycle after the operands.
  always_ff @(posedge clk_i) begin
    prod_o <= {17'b0, a_i} * {32'b0, b_i};
  end

endmodule

`default_nettype wire

// ----- rtl/mutation_operator_scheduler_unit.sv -----
// Mutation operator scheduler top level: sequencer, configuration registers
// and per-slot stores. Depends on mos_pkg, mos_ram, mos_prng and mos_mul.
//
// One command at a time: busy_o is high from the accepted start beat until
// its single result beat, which res_valid_o marks for one cycle and which the
// receiver cannot hold off. A select takes one scan step per operator looked
// at (up to num_operators + 1), paced by the one-bit scan. A feedback reads,
// multiplies and draws each operator in use in turn, paced by the shared
// multiplier and the probability RAM port; a feedback that ends a generation
// adds the elite mask reads of every group and a pass of fitness clearing.
// Slot numbers at or above NUM_SEEDS are reduced by steps of NUM_SEEDS.
// After reset a clearing pass draws the first mask of every slot; busy_o
// stays high meanwhile, configuration writes are taken.
`default_nettype none

module mutation_operator_scheduler_unit
  import mos_pkg::*;
#(
  parameter int NUM_SEEDS = 64
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             start_i,
  output logic                  busy_o,
  input  wire cmd_t             cmd_i,
  output logic                  res_valid_o,
  output res_t                  res_o,
  input  wire logic             cfg_we_i,
  input  wire logic [1:0]       cfg_idx_i,
  input  wire logic [CFG_W-1:0] cfg_wdata_i
);

  localparam int SLOT_W = (NUM_SEEDS > 1) ? $clog2(NUM_SEEDS) : 1;
  localparam int XW     = (SLOT_W > 6) ? SLOT_W : 6;
  localparam int FM_D   = NUM_SEEDS * POPULATION;
  localparam int FAW    = (FM_D > 1) ? $clog2(FM_D) : 1;
  localparam logic [10:0] NS11 = 11'(NUM_SEEDS);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SEEDS - 1);

  typedef enum logic [18:0] {
    S_INIT      = 19'd1 << 0,
    S_INIT_MASK = 19'd1 << 1,
    S_IDLE      = 19'd1 << 2,
    S_RED       = 19'd1 << 3,
    S_SEL_MASK  = 19'd1 << 4,
    S_SEL_START = 19'd1 << 5,
    S_SEL_SCAN  = 19'd1 << 6,
    S_FB_GRP    = 19'd1 << 7,
    S_FB_FIT    = 19'd1 << 8,
    S_FB_CMP    = 19'd1 << 9,
    S_GEN_RD    = 19'd1 << 10,
    S_GEN_MK    = 19'd1 << 11,
    S_GEN_CAP   = 19'd1 << 12,
    S_GEN_CLR   = 19'd1 << 13,
    S_FB_POSW   = 19'd1 << 14,
    S_OP_RD     = 19'd1 << 15,
    S_OP_MUL    = 19'd1 << 16,
    S_OP_WR     = 19'd1 << 17,
    S_MASK_W    = 19'd1 << 18
  } state_e;

  state_e state_q, state_d;

  // Configuration registers.
  logic [5:0]       num_ops_q;
  logic [15:0]      rate_q;
  logic [CFG_W-1:0] seed_q;
  logic             seed_pend_q, seed_pend_d;

  // Sequencer working registers.
  logic [5:0]        slot_q, slot_d;
  logic              cmd_fb_q, cmd_fb_d;
  logic [15:0]       paths_q, paths_d;
  logic [POS_W-1:0]  pos_q, pos_d, posn_q, posn_d, best_q, best_d;
  logic [GRP_W-1:0]  grp_q, grp_d, g_q, g_d;
  logic [5:0]        idx_q, idx_d, tries_q, tries_d;
  logic [OP_W-1:0]   op_q, op_d;
  logic [31:0]       mask_q, mask_d, acc_q, acc_d;
  logic [31:0]       bm_q [ELITE_GROUPS];
  logic [31:0]       bm_d [ELITE_GROUPS];
  logic [PROB_W-1:0] p_q, p_d;
  logic              gen_q, gen_d;
  logic [SLOT_W-1:0] init_s_q, init_s_d;
  logic              res_valid_q, res_valid_d;
  res_t              res_q, res_d;

  // Shared units and RAM ports.
  logic              prng_step, prng_load;
  logic [CFG_W-1:0]  prng_seed, prng_next;
  logic [31:0]       mul_a;
  logic [16:0]       mul_b;
  logic [48:0]       mul_p;

  logic                      pos_we, gb_we, prob_we, fit_we, mask_we;
  logic [POS_W-1:0]          pos_wdata, gb_wdata, pos_rdata, gb_rdata;
  logic [GRP_W-1:0]          gb_g;
  logic [OP_W-1:0]           prob_i;
  logic [PROB_W-1:0]         prob_wdata, prob_rdata;
  logic [FIT_W-1:0]          fit_wdata, fit_rdata;
  logic [31:0]               mask_wdata, mask_rdata;
  logic [POS_W-1:0]          fit_k, mask_k;
  logic [SLOT_W-1:0]         cur_s;
  logic [XW-1:0]             s_wide;
  logic [SLOT_W+GRP_W-1:0]   gb_addr;
  logic [SLOT_W+OP_W-1:0]    prob_addr;
  logic [FAW-1:0]            fit_addr, mask_addr;

  // Operator count in use and the updated probability.
  logic [5:0]        n_ops;
  logic [2:0]        elite_cnt;
  logic [17:0]       rate_c;
  logic [35:0]       upd_sum;
  logic [PROB_W-1:0] p_new, p_use;
  logic              draw_bit;
  logic              cfg_seed_wr, init_busy;

  assign n_ops = (num_ops_q == '0) ? 6'd1 :
                 (num_ops_q > 6'(MAX_OPERATORS)) ? 6'(MAX_OPERATORS) : num_ops_q;

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  // Slot index of the current access.
  assign s_wide    = XW'(slot_q);
  assign cur_s     = (state_q == S_INIT || state_q == S_INIT_MASK) ? init_s_q
                                                                   : s_wide[SLOT_W-1:0];
  assign gb_addr   = {cur_s, gb_g};
  assign prob_addr = {cur_s, prob_i};
  assign fit_addr  = FAW'(cur_s) * FAW'(POPULATION) + FAW'(fit_k);
  assign mask_addr = FAW'(cur_s) * FAW'(POPULATION) + FAW'(mask_k);

  // Elite vote for operator idx, clamped to between one and one less than the group count.
  always_comb begin
    elite_cnt = 3'(bm_q[0][idx_q[4:0]]) + 3'(bm_q[1][idx_q[4:0]])
              + 3'(bm_q[2][idx_q[4:0]]) + 3'(bm_q[3][idx_q[4:0]]);
    if (elite_cnt >= 3'(ELITE_GROUPS)) elite_cnt = 3'(ELITE_GROUPS - 1);
    if (elite_cnt == '0) elite_cnt = 3'd1;
    rate_c = (elite_cnt[1] ? {1'b0, rate_q, 1'b0} : 18'd0)
           + (elite_cnt[0] ? {2'b0, rate_q} : 18'd0);
  end

  // p' = ((1-r)*p*4 + r*c) / 4, rounded half up, saturated.
  always_comb begin
    upd_sum = {2'b0, mul_p[31:0], 2'b0} + {2'b0, rate_c, 16'b0} + 36'h20000;
    p_new   = (upd_sum[35:18] > 18'(PROB_MAX)) ? PROB_MAX : upd_sum[33:18];
    p_use   = gen_q ? p_new : p_q;
  end

  assign draw_bit    = (prng_next[31:16] < p_use);
  assign init_busy   = (state_q == S_INIT || state_q == S_INIT_MASK);
  assign cfg_seed_wr = cfg_we_i && (cfg_idx_i == CFG_SEED);

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    slot_d      = slot_q;
    cmd_fb_d    = cmd_fb_q;
    paths_d     = paths_q;
    pos_d       = pos_q;
    posn_d      = posn_q;
    best_d      = best_q;
    grp_d       = grp_q;
    g_d         = g_q;
    idx_d       = idx_q;
    tries_d     = tries_q;
    op_d        = op_q;
    mask_d      = mask_q;
    acc_d       = acc_q;
    bm_d        = bm_q;
    p_d         = p_q;
    gen_d       = gen_q;
    init_s_d    = init_s_q;
    seed_pend_d = seed_pend_q;
    res_valid_d = 1'b0;
    res_d       = res_q;

    prng_step  = 1'b0;
    prng_load  = 1'b0;
    prng_seed  = seed_q;
    mul_a      = '0;
    mul_b      = '0;
    pos_we     = 1'b0;
    pos_wdata  = '0;
    gb_we      = 1'b0;
    gb_g       = grp_q;
    gb_wdata   = pos_q;
    prob_we    = 1'b0;
    prob_i     = idx_q[4:0];
    prob_wdata = p_new;
    fit_we     = 1'b0;
    fit_k      = best_q;
    fit_wdata  = '0;
    mask_we    = 1'b0;
    mask_k     = pos_q;
    mask_wdata = acc_q;

    // Seed writes load the generator at once, or after the clearing pass.
    if (cfg_seed_wr) begin
      if (init_busy) begin
        seed_pend_d = 1'b1;
      end else begin
        prng_load = 1'b1;
        prng_seed = cfg_wdata_i;
      end
    end

    unique case (state_q)
      S_INIT: begin
        prng_step  = 1'b1;
        acc_d[idx_q[4:0]] = (prng_next[31:16] < PROB_HALF);
        prob_we    = 1'b1;
        prob_wdata = PROB_HALF;
        fit_k      = idx_q[4:0];
        fit_we     = (idx_q < 6'(POPULATION));
        gb_g       = idx_q[1:0];
        gb_wdata   = group_start(idx_q[1:0]);
        gb_we      = (idx_q < 6'(ELITE_GROUPS));
        pos_we     = (idx_q == '0);
        idx_d      = idx_q + 6'd1;
        if (idx_q == 6'(MAX_OPERATORS - 1)) begin
          state_d = S_INIT_MASK;
        end
      end
      S_INIT_MASK: begin
        mask_we = 1'b1;
        mask_k  = '0;
        acc_d   = '0;
        idx_d   = '0;
        if (init_s_q == LAST_SLOT) begin
          state_d = S_IDLE;
          if (seed_pend_q || cfg_seed_wr) begin
            prng_load   = 1'b1;
            prng_seed   = cfg_seed_wr ? cfg_wdata_i : seed_q;
            seed_pend_d = 1'b0;
          end
        end else begin
          init_s_d = init_s_q + SLOT_W'(1);
          state_d  = S_INIT;
        end
      end
      S_IDLE: begin
        if (start_i) begin
          slot_d   = cmd_i.seed_slot;
          cmd_fb_d = cmd_i.command;
          paths_d  = cmd_i.new_paths;
          gen_d    = 1'b0;
          state_d  = S_RED;
        end
      end
      S_RED: begin
        // Bring the slot below NUM_SEEDS; the position read runs meanwhile.
        if ({5'b0, slot_q} >= NS11) begin
          slot_d = slot_q - NS11[5:0];
        end else begin
          state_d = cmd_fb_q ? S_FB_GRP : S_SEL_MASK;
        end
      end
      S_SEL_MASK: begin
        mask_k    = pos_rdata;
        prng_step = 1'b1;
        mul_a     = prng_next;
        mul_b     = 17'(n_ops);
        state_d   = S_SEL_START;
      end
      S_SEL_START: begin
        mask_d  = mask_rdata;
        op_d    = mul_p[36:32];
        tries_d = '0;
        state_d = S_SEL_SCAN;
      end
      S_SEL_SCAN: begin
        if (mask_q[op_q] || tries_q == n_ops) begin
          res_valid_d           = 1'b1;
          res_d.operator_id     = op_q;
          res_d.generation_done = 1'b0;
          state_d               = S_IDLE;
        end else begin
          tries_d = tries_q + 6'd1;
          op_d    = ((6'(op_q) + 6'd1) == n_ops) ? '0 : op_q + OP_W'(1);
        end
      end
      S_FB_GRP: begin
        pos_d   = pos_rdata;
        grp_d   = pos_to_group(pos_rdata);
        gb_g    = pos_to_group(pos_rdata);
        state_d = S_FB_FIT;
      end
      S_FB_FIT: begin
        best_d  = gb_rdata;
        fit_k   = gb_rdata;
        state_d = S_FB_CMP;
      end
      S_FB_CMP: begin
        fit_we    = 1'b1;
        fit_k     = pos_q;
        fit_wdata = paths_q;
        // Strict gain over the group best replaces it.
        gb_we = (best_q != pos_q) && (paths_q > fit_rdata);
        if (pos_q == POS_W'(POPULATION - 1)) begin
          gen_d   = 1'b1;
          g_d     = '0;
          state_d = S_GEN_RD;
        end else begin
          posn_d  = pos_q + POS_W'(1);
          state_d = S_FB_POSW;
        end
      end
      S_GEN_RD: begin
        gb_g    = g_q;
        state_d = S_GEN_MK;
      end
      S_GEN_MK: begin
        mask_k  = gb_rdata;
        state_d = S_GEN_CAP;
      end
      S_GEN_CAP: begin
        bm_d[g_q] = mask_rdata;
        g_d       = g_q + GRP_W'(1);
        if (g_q == GRP_W'(ELITE_GROUPS - 1)) begin
          idx_d   = '0;
          state_d = S_GEN_CLR;
        end else begin
          state_d = S_GEN_RD;
        end
      end
      S_GEN_CLR: begin
        // Clear all fitness entries and restart the group bests.
        fit_we   = 1'b1;
        fit_k    = idx_q[4:0];
        gb_g     = idx_q[1:0];
        gb_wdata = group_start(idx_q[1:0]);
        gb_we    = (idx_q < 6'(ELITE_GROUPS));
        idx_d    = idx_q + 6'd1;
        if (idx_q == 6'(POPULATION - 1)) begin
          posn_d  = '0;
          state_d = S_FB_POSW;
        end
      end
      S_FB_POSW: begin
        pos_we    = 1'b1;
        pos_wdata = posn_q;
        acc_d     = '0;
        idx_d     = '0;
        state_d   = S_OP_RD;
      end
      S_OP_RD: begin
        state_d = S_OP_MUL;
      end
      S_OP_MUL: begin
        p_d     = prob_rdata;
        mul_a   = 32'(17'h10000 - {1'b0, rate_q});
        mul_b   = {1'b0, prob_rdata};
        state_d = S_OP_WR;
      end
      S_OP_WR: begin
        // Update (at a generation end), then draw this operator's bit.
        prob_we   = gen_q;
        prng_step = 1'b1;
        acc_d[idx_q[4:0]] = draw_bit;
        idx_d     = idx_q + 6'd1;
        state_d   = ((idx_q + 6'd1) == n_ops) ? S_MASK_W : S_OP_RD;
      end
      S_MASK_W: begin
        mask_we               = 1'b1;
        mask_k                = posn_q;
        res_valid_d           = 1'b1;
        res_d.operator_id     = '0;
        res_d.generation_done = gen_q;
        state_d               = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_ops_q <= 6'd16;
      rate_q    <= 16'd19661;
      seed_q    <= 32'd1;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_NUM_OPS: num_ops_q <= cfg_wdata_i[5:0];
        CFG_RATE:    rate_q    <= cfg_wdata_i[15:0];
        CFG_SEED:    seed_q    <= cfg_wdata_i;
        default:     ;
      endcase
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_INIT;
      init_s_q    <= '0;
      idx_q       <= '0;
      acc_q       <= '0;
      seed_pend_q <= 1'b0;
      res_valid_q <= 1'b0;
      res_q       <= '0;
      gen_q       <= 1'b0;
      slot_q      <= '0;
      cmd_fb_q    <= 1'b0;
      paths_q     <= '0;
      pos_q       <= '0;
      posn_q      <= '0;
      best_q      <= '0;
      grp_q       <= '0;
      g_q         <= '0;
      tries_q     <= '0;
      op_q        <= '0;
      mask_q      <= '0;
      p_q         <= '0;
      bm_q        <= '{default: '0};
    end else begin
      state_q     <= state_d;
      init_s_q    <= init_s_d;
      idx_q       <= idx_d;
      acc_q       <= acc_d;
      seed_pend_q <= seed_pend_d;
      res_valid_q <= res_valid_d;
      res_q       <= res_d;
      gen_q       <= gen_d;
      slot_q      <= slot_d;
      cmd_fb_q    <= cmd_fb_d;
      paths_q     <= paths_d;
      pos_q       <= pos_d;
      posn_q      <= posn_d;
      best_q      <= best_d;
      grp_q       <= grp_d;
      g_q         <= g_d;
      tries_q     <= tries_d;
      op_q        <= op_d;
      mask_q      <= mask_d;
      p_q         <= p_d;
      bm_q        <= bm_d;
    end
  end

  // Shared units.
  mos_prng u_prng (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (prng_step),
    .load_i (prng_load),
    .seed_i (prng_seed),
    .next_o (prng_next)
  );

  mos_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (mul_p)
  );

  // Per-slot stores.
  mos_ram #(.WIDTH(POS_W), .DEPTH(NUM_SEEDS)) u_pos_ram (
    .clk_i   (clk_i),
    .we_i    (pos_we),
    .addr_i  (cur_s),
    .wdata_i (pos_wdata),
    .rdata_o (pos_rdata)
  );

  mos_ram #(.WIDTH(POS_W), .DEPTH(NUM_SEEDS * ELITE_GROUPS)) u_gb_ram (
    .clk_i   (clk_i),
    .we_i    (gb_we),
    .addr_i  (gb_addr),
    .wdata_i (gb_wdata),
    .rdata_o (gb_rdata)
  );

  mos_ram #(.WIDTH(PROB_W), .DEPTH(NUM_SEEDS * MAX_OPERATORS)) u_prob_ram (
    .clk_i   (clk_i),
    .we_i    (prob_we),
    .addr_i  (prob_addr),
    .wdata_i (prob_wdata),
    .rdata_o (prob_rdata)
  );

  mos_ram #(.WIDTH(FIT_W), .DEPTH(FM_D)) u_fit_ram (
    .clk_i   (clk_i),
    .we_i    (fit_we),
    .addr_i  (fit_addr),
    .wdata_i (fit_wdata),
    .rdata_o (fit_rdata)
  );

  mos_ram #(.WIDTH(32), .DEPTH(FM_D)) u_mask_ram (
    .clk_i   (clk_i),
    .we_i    (mask_we),
    .addr_i  (mask_addr),
    .wdata_i (mask_wdata),
    .rdata_o (mask_rdata)
  );

  // A result beat is only given once the sequencer is back at rest.
  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy_o) else $error("result beat while busy");

  // An accepted command always makes the block busy.
  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o) |=> busy_o) else $error("start not taken");

  // Result beats are single pulses.
  a_res_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("result beat repeated");

  // A generation end only comes from a feedback, which reports operator zero.
  a_gen_op: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.generation_done) |-> (res_o.operator_id == '0))
    else $error("generation end with operator");

endmodule

`default_nettype wire

// ----- tb/sv/mutation_operator_scheduler_unit_tb.sv -----
// Testbench for the mutation operator scheduler: a scoreboard class mirrors the
// per-slot learner state and checks every result beat. Depends on mos_pkg and
// the RTL of mutation_operator_scheduler_unit.
`timescale 1ns / 1ps

module mutation_operator_scheduler_unit_tb;
  import mos_pkg::*;

  localparam int SLOTS = 64;

  // Mirror of the learner state with its own random generator.
  class op_sched_scoreboard;
    bit [5:0]  num_ops_reg;
    bit [15:0] rate_reg;
    bit [31:0] rng;
    bit [4:0]  eval_pos [SLOTS];
    bit [15:0] fitness [SLOTS][POPULATION];
    bit [4:0]  best_of_group [SLOTS][ELITE_GROUPS];
    bit [31:0] masks [SLOTS][POPULATION];
    bit [15:0] prob [SLOTS][MAX_OPERATORS];
    res_t      pending[$];

    function bit [31:0] rng_step();
      bit [31:0] x;
      x = rng;
      x ^= x << 13;
      x ^= x >> 17;
      x ^= x << 5;
      rng = x;
      return x;
    endfunction

    function int unsigned ops_active();
      if (num_ops_reg == 0) return 1;
      if (num_ops_reg > MAX_OPERATORS) return MAX_OPERATORS;
      return num_ops_reg;
    endfunction

    function void restart_groups(int s);
      for (int g = 0; g < ELITE_GROUPS; g++) best_of_group[s][g] = 5'(g * GROUP_SIZE);
    endfunction

    // State after reset, including the clearing pass that draws every first mask.
    function void power_on();
      bit [31:0] m;
      bit [31:0] draw;
      num_ops_reg = 16;
      rate_reg = 16'd19661;
      rng = 32'd1;
      pending.delete();
      for (int s = 0; s < SLOTS; s++) begin
        eval_pos[s] = 0;
        restart_groups(s);
        for (int k = 0; k < POPULATION; k++) begin
          fitness[s][k] = 0;
          masks[s][k] = 0;
        end
        m = 0;
        for (int i = 0; i < MAX_OPERATORS; i++) begin
          prob[s][i] = PROB_HALF;
          draw = rng_step();
          if (draw[31:16] < 16'h8000) m[i] = 1'b1;
        end
        masks[s][0] = m;
      end
    endfunction

    function void write_reg(cfg_idx_e idx, bit [31:0] val);
      case (idx)
        CFG_NUM_OPS: num_ops_reg = val[5:0];
        CFG_RATE:    rate_reg = val[15:0];
        CFG_SEED:    rng = (val == 0) ? 32'd1 : val;
        default: ;
      endcase
    endfunction

    // Updates the mirror for one accepted command beat and queues its result.
    function void note_command(cmd_t c);
      int unsigned n, s, pos, op, tries, grp, best, cnt;
      bit [31:0] mask;
      bit [31:0] draw;
      bit [63:0] num, pn, r;
      res_t res;
      n = ops_active();
      s = c.seed_slot;
      pos = eval_pos[s] % POPULATION;
      res = '0;
      if (c.command == 1'b0) begin
        mask = masks[s][pos];
        op = int'((64'(rng_step()) * 64'(n)) >> 32);
        tries = 0;
        while (mask[op] == 1'b0 && tries < n) begin
          tries++;
          op = (op + 1) % n;
        end
        res.operator_id = 5'(op);
      end else begin
        grp = pos / GROUP_SIZE;
        best = best_of_group[s][grp] % POPULATION;
        fitness[s][pos] = c.new_paths;
        if (c.new_paths > fitness[s][best]) best_of_group[s][grp] = 5'(pos);
        pos++;
        if (pos >= POPULATION) begin
          r = 64'(rate_reg);
          for (int i = 0; i < n; i++) begin
            cnt = 0;
            for (int g = 0; g < ELITE_GROUPS; g++)
              cnt += masks[s][best_of_group[s][g] % POPULATION][i];
            if (cnt >= ELITE_GROUPS) cnt = ELITE_GROUPS - 1;
            if (cnt == 0) cnt = 1;
            num = (64'd65536 - r) * 64'(prob[s][i]) * ELITE_GROUPS + r * 64'(cnt) * 64'd65536;
            pn = (num + 64'(ELITE_GROUPS) * 64'd32768) / (64'(ELITE_GROUPS) * 64'd65536);
            if (pn > 64'd65535) pn = 64'd65535;
            prob[s][i] = 16'(pn);
          end
          pos = 0;
          restart_groups(s);
          for (int k = 0; k < POPULATION; k++) fitness[s][k] = 0;
          res.generation_done = 1'b1;
        end
        eval_pos[s] = 5'(pos);
        mask = 0;
        for (int i = 0; i < n; i++) begin
          draw = rng_step();
          if (draw[31:16] < prob[s][i]) mask[i] = 1'b1;
        end
        masks[s][pos] = mask;
      end
      pending.push_back(res);
    endfunction

    // Compares one result beat with the oldest expectation; returns 1 on a match.
    function bit check_result(res_t got, output string msg);
      res_t exp_res;
      if (pending.size() == 0) begin
        msg = $sformatf("unexpected result beat op=%0d done=%0d",
                        got.operator_id, got.generation_done);
        return 0;
      end
      exp_res = pending.pop_front();
      if (got.operator_id !== exp_res.operator_id) begin
        msg = $sformatf("operator_id got %0d want %0d", got.operator_id, exp_res.operator_id);
        return 0;
      end
      if (got.generation_done !== exp_res.generation_done) begin
        msg = $sformatf("generation_done got %0d want %0d",
                        got.generation_done, exp_res.generation_done);
        return 0;
      end
      return 1;
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             start_i;
  logic             busy_o;
  cmd_t             cmd_i;
  logic             res_valid_o;
  res_t             res_o;
  logic             cfg_we_i;
  logic [1:0]       cfg_idx_i;
  logic [CFG_W-1:0] cfg_wdata_i;

  op_sched_scoreboard sb;
  int unsigned mismatches = 0;
  bit          idle_gaps;
  bit [5:0]    hot_slots [4];

  mutation_operator_scheduler_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start_i),
    .busy_o      (busy_o),
    .cmd_i       (cmd_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  task automatic report_mismatch(string msg);
    $display("MISMATCH at %0t: %s", $realtime, msg);
    mismatches++;
  endtask

  // Every result beat is checked at the edge that ends its cycle.
  always @(posedge clk_i) begin
    string msg;
    if (rst_ni && res_valid_o) begin
      if (!sb.check_result(res_o, msg)) report_mismatch(msg);
    end
  end

  // One register write, then the write enable is taken low again.
  task automatic write_cfg(cfg_idx_e idx, bit [31:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.write_reg(idx, val);
    @(posedge clk_i);
  endtask

  // Drives one command beat, after an optional idle burst, and waits until the block is idle again.
  task automatic send_command(cmd_t c);
    int unsigned gap;
    gap = 0;
    if (idle_gaps && $urandom_range(0, 2) == 0) gap = $urandom_range(1, 14);
    if (gap != 0) begin
      start_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start_i <= 1'b1;
    cmd_i <= c;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    sb.note_command(c);
  endtask

  task automatic drain();
    start_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending.size() != 0 || busy_o) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  function automatic cmd_t random_command();
    cmd_t c;
    c.command = $urandom_range(0, 1);
    // Most beats go to a few slots so that generations complete often.
    if ($urandom_range(0, 9) < 8) c.seed_slot = hot_slots[$urandom_range(0, 3)];
    else c.seed_slot = $urandom_range(0, 63);
    case ($urandom_range(0, 3))
      0: c.new_paths = 16'hFFFF;
      1: c.new_paths = 16'(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20));
      default: c.new_paths = $urandom_range(0, 65535);
    endcase
    return c;
  endfunction

  initial begin
    bit [5:0]  ops_set  [7];
    bit [15:0] rate_set [7];
    bit [31:0] seed_set [7];
    cmd_t c;
    ops_set  = '{6'd1, 6'd32, 6'd0, 6'd63, 6'd16, 6'd5, 6'd27};
    rate_set = '{16'd0, 16'hFFFF, 16'd19661, 16'd1, 16'd40000, 16'd65534, 16'd8000};
    seed_set = '{32'd0, 32'hFFFFFFFF, 32'h80000000, 32'd1, 32'h12345678, 32'd2, 32'h5A5A5A5A};
    sb = new();
    sb.power_on();
    rst_ni = 1'b0;
    start_i = 1'b0;
    cmd_i = '0;
    cfg_we_i = 1'b0;
    cfg_idx_i = CFG_NUM_OPS;
    cfg_wdata_i = '0;
    idle_gaps = 1'b1;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);

    // Directed: field extremes and both commands under reset settings.
    c = '{command: 1'b0, seed_slot: 6'd0, new_paths: 16'hFFFF};
    send_command(c);
    c = '{command: 1'b0, seed_slot: 6'd63, new_paths: 16'h0000};
    send_command(c);
    c = '{command: 1'b1, seed_slot: 6'd63, new_paths: 16'hFFFF};
    send_command(c);
    c = '{command: 1'b1, seed_slot: 6'd0, new_paths: 16'h0000};
    send_command(c);
    // All but the last feedback of a generation on one slot, with gains and ties against the group best.
    for (int k = 0; k < 19; k++) begin
      c = '{command: 1'b1, seed_slot: 6'd42, new_paths: 16'((k % 3) * 100)};
      send_command(c);
    end
    c = '{command: 1'b0, seed_slot: 6'd42, new_paths: 16'h1234};
    send_command(c);
    drain();

    // Random phases under different settings; the last phase runs without idling.
    for (int ph = 0; ph < 7; ph++) begin
      write_cfg(CFG_NUM_OPS, 32'(ops_set[ph]));
      write_cfg(CFG_RATE, 32'(rate_set[ph]));
      write_cfg(CFG_SEED, seed_set[ph]);
      for (int h = 0; h < 4; h++) hot_slots[h] = $urandom_range(0, 63);
      idle_gaps = (ph != 6) && (ph != 3);
      for (int k = 0; k < 240; k++) begin
        if (ph != 6 && k % 60 == 0) idle_gaps = ~idle_gaps;
        send_command(random_command());
      end
      drain();
    end

    repeat (50) @(posedge clk_i);
    if (sb.pending.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", sb.pending.size()));
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #8000000;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/mos_pkg.sv
rtl/mos_ram.sv
rtl/mos_prng.sv
rtl/mos_mul.sv
rtl/mutation_operator_scheduler_unit.sv
tb/sv/mutation_operator_scheduler_unit_tb.sv
